// ===== design/lgct_pkg.sv =====
// ----------------------------------------------------------------------------
// lgct_pkg
// Shared types and constants for the line grid cell traversal unit.
// ----------------------------------------------------------------------------
package lgct_pkg;

    localparam int COORD_W    = 24;   // Q16.8 coordinate width
    localparam int SIZE_W     = 23;   // cell size width
    localparam int COUNT_W    = 6;    // columns / rows register width
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IDX_OUT_W  = 5;    // output index width
    localparam int ITER       = 24;   // divider / multiplier iterations
    localparam int CNT_W      = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMNS     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS        = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_S,
        S_DIV_E,
        S_NUM,
        S_MUL,
        S_WALK
    } t_state;

    typedef struct packed {
        logic load;      // latch request, set up start-point division
        logic div_step;  // one restoring-division bit on both axes
        logic fin_s;     // last bit of start division: clamp start cell
        logic fin_e;     // last bit of end division: clamp end cell
        logic num;       // boundary distance of the start cell
        logic mul_step;  // one shift-add bit of the time products
        logic walk;      // emit current cell and step
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a cell
        logic last;      // current cell is the end cell
    } t_sts;

endpackage

// ===== design/lgct_ctrl.sv =====
// ----------------------------------------------------------------------------
// lgct_ctrl
// Sequencer: division, setup, product accumulation and cell walk phases.
// ----------------------------------------------------------------------------
module lgct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  lgct_pkg::t_sts    i_sts,
    output lgct_pkg::t_cmd    o_cmd
);

    lgct_pkg::t_state                r_state, n_state;
    logic [lgct_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            cnt_done;
    logic                            counting;

    assign cnt_done = (r_cnt == lgct_pkg::CNT_W'(lgct_pkg::ITER - 1));
    assign counting = (r_state == lgct_pkg::S_DIV_S) || (r_state == lgct_pkg::S_DIV_E) ||
                      (r_state == lgct_pkg::S_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgct_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_cnt = (counting && !cnt_done) ? r_cnt + 1'b1 : '0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lgct_pkg::S_IDLE:  if (i_s_tvalid) n_state = lgct_pkg::S_DIV_S;
            lgct_pkg::S_DIV_S: if (cnt_done) n_state = lgct_pkg::S_DIV_E;
            lgct_pkg::S_DIV_E: if (cnt_done) n_state = lgct_pkg::S_NUM;
            lgct_pkg::S_NUM:   n_state = lgct_pkg::S_MUL;
            lgct_pkg::S_MUL:   if (cnt_done) n_state = lgct_pkg::S_WALK;
            lgct_pkg::S_WALK:  if (i_sts.out_free && i_sts.last) n_state = lgct_pkg::S_IDLE;
            default:           n_state = lgct_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_s_tready     = 1'b0;
        case (r_state)
            lgct_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            lgct_pkg::S_DIV_S: begin
                o_cmd.div_step = 1'b1;
                o_cmd.fin_s    = cnt_done;
            end
            lgct_pkg::S_DIV_E: begin
                o_cmd.div_step = 1'b1;
                o_cmd.fin_e    = cnt_done;
            end
            lgct_pkg::S_NUM:  o_cmd.num      = 1'b1;
            lgct_pkg::S_MUL:  o_cmd.mul_step = 1'b1;
            lgct_pkg::S_WALK: o_cmd.walk     = i_sts.out_free;
            default: ;
        endcase
    end

    ap_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgct_pkg::S_IDLE) |-> (r_cnt == '0))
        else $error("counter not cleared in idle");

    ap_walk_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.walk && i_sts.last) |=> (r_state == lgct_pkg::S_IDLE))
        else $error("walk did not end after last cell");

    ap_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == lgct_pkg::S_DIV_S) && (r_cnt == '0))
        else $error("request load did not start division");

endmodule

// ===== design/lgct_dp.sv =====
// ----------------------------------------------------------------------------
// lgct_dp
// Datapath: config registers, two restoring dividers, boundary-time
// shift-add products and the incremental cell walk with output register.
// ----------------------------------------------------------------------------
module lgct_dp #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lgct_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [lgct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [4*lgct_pkg::COORD_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [15:0]                         o_m_tdata,
    output logic                                o_m_tlast,
    input  lgct_pkg::t_cmd                      i_cmd,
    output lgct_pkg::t_sts                      o_sts
);

    localparam int CW   = lgct_pkg::COORD_W;
    localparam int SW   = lgct_pkg::SIZE_W;
    localparam int MAXN = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int IW   = ($clog2(MAXN) > lgct_pkg::IDX_OUT_W) ? $clog2(MAXN)
                                                               : lgct_pkg::IDX_OUT_W;
    localparam int LW   = 11;
    localparam int NW   = IW + 26;            // boundary distance, signed
    localparam int MW   = IW + 1 + SW;        // cell index times size
    localparam int PW   = NW + CW;            // boundary time product, signed

    // configuration
    logic signed [CW-1:0]          r_org_x, r_org_y;
    logic [SW-1:0]                 r_cell_w, r_cell_h;
    logic [lgct_pkg::COUNT_W-1:0]  r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_cell_w <= SW'(256);
            r_cell_h <= SW'(256);
            r_cols   <= lgct_pkg::COUNT_W'(1);
            r_rows   <= lgct_pkg::COUNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lgct_pkg::REG_ORIGIN_X:    r_org_x  <= i_cfg_data;
                lgct_pkg::REG_ORIGIN_Y:    r_org_y  <= i_cfg_data;
                lgct_pkg::REG_CELL_WIDTH:  r_cell_w <= i_cfg_data[SW-1:0];
                lgct_pkg::REG_CELL_HEIGHT: r_cell_h <= i_cfg_data[SW-1:0];
                lgct_pkg::REG_COLUMNS:     r_cols   <= i_cfg_data[lgct_pkg::COUNT_W-1:0];
                lgct_pkg::REG_ROWS:        r_rows   <= i_cfg_data[lgct_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0] size_w, size_h;
    logic [IW-1:0] xlim, ylim;

    assign size_w = (r_cell_w == '0) ? SW'(1) : r_cell_w;
    assign size_h = (r_cell_h == '0) ? SW'(1) : r_cell_h;

    function automatic logic [IW-1:0] last_index(input logic [lgct_pkg::COUNT_W-1:0] cnt,
                                                 input int maxv);
        logic [LW-1:0] c;
        c = LW'(cnt);
        if (c == '0)           return '0;
        else if (c > LW'(maxv)) return IW'(maxv - 1);
        else                   return IW'(c - 1'b1);
    endfunction

    assign xlim = last_index(r_cols, MAX_COLUMNS);
    assign ylim = last_index(r_rows, MAX_ROWS);

    function automatic logic [IW-1:0] clamp_cell(input logic [CW-1:0] q, input logic neg,
                                                 input logic [IW-1:0] lim);
        if (neg)                 return '0;
        else if (q > CW'(lim))   return lim;
        else                     return q[IW-1:0];
    endfunction

    // request unpack, offsets from the grid origin
    logic signed [CW:0] px, py, qx, qy, dx, dy;
    logic [CW-1:0]      adx, ady;

    assign px  = $signed({i_s_tdata[CW-1], i_s_tdata[CW-1:0]}) -
                 $signed({r_org_x[CW-1], r_org_x});
    assign py  = $signed({i_s_tdata[2*CW-1], i_s_tdata[2*CW-1:CW]}) -
                 $signed({r_org_y[CW-1], r_org_y});
    assign qx  = $signed({i_s_tdata[3*CW-1], i_s_tdata[3*CW-1:2*CW]}) -
                 $signed({r_org_x[CW-1], r_org_x});
    assign qy  = $signed({i_s_tdata[4*CW-1], i_s_tdata[4*CW-1:3*CW]}) -
                 $signed({r_org_y[CW-1], r_org_y});
    assign dx  = qx - px;
    assign dy  = qy - py;
    assign adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    assign ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];

    logic signed [CW:0] r_px, r_py, r_qx, r_qy;
    logic               r_dx_pos, r_dy_pos;
    logic [CW-1:0]      r_adx, r_ady;

    // restoring dividers, one quotient bit per cycle on each axis
    logic [CW-1:0] r_nx, r_ny, r_divq_x, r_divq_y;
    logic [SW-1:0] r_rx, r_ry;
    logic          r_negx, r_negy;
    logic [CW-1:0] trial_x, trial_y, n_divq_x, n_divq_y;
    logic          ge_x, ge_y;

    assign trial_x  = {r_rx, r_nx[CW-1]};
    assign trial_y  = {r_ry, r_ny[CW-1]};
    assign ge_x     = trial_x >= CW'(size_w);
    assign ge_y     = trial_y >= CW'(size_h);
    assign n_divq_x = {r_divq_x[CW-2:0], ge_x};
    assign n_divq_y = {r_divq_y[CW-2:0], ge_y};

    // cells and products
    logic [IW-1:0]         r_cx, r_cy, r_ex, r_ey;
    logic [MW-1:0]         mx, my;
    logic signed [NW-1:0]  numx, numy;
    logic signed [PW-1:0]  r_mx, r_my, r_tx, r_ty;
    logic [PW-1:0]         r_wm, r_hm, r_wstep, r_hstep;
    logic [CW-1:0]         r_bx, r_by;     // multiplier bits: ady for x, adx for y

    assign mx   = (MW'({1'b0, r_cx}) + MW'(r_dx_pos)) * MW'(size_w);
    assign my   = (MW'({1'b0, r_cy}) + MW'(r_dy_pos)) * MW'(size_h);
    assign numx = r_dx_pos ? $signed(NW'(mx)) - NW'(r_px) : NW'(r_px) - $signed(NW'(mx));
    assign numy = r_dy_pos ? $signed(NW'(my)) - NW'(r_py) : NW'(r_py) - $signed(NW'(my));

    logic need_x, need_y, last, step_x;

    assign need_x = (r_cx != r_ex);
    assign need_y = (r_cy != r_ey);
    assign last   = !need_x && !need_y;
    assign step_x = (need_x && need_y) ? (r_tx < r_ty) : need_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= px;
            r_py     <= py;
            r_qx     <= qx;
            r_qy     <= qy;
            r_dx_pos <= !dx[CW] && (dx != '0);
            r_dy_pos <= !dy[CW] && (dy != '0);
            r_adx    <= adx;
            r_ady    <= ady;
            r_nx     <= px[CW-1:0];
            r_ny     <= py[CW-1:0];
            r_negx   <= px[CW];
            r_negy   <= py[CW];
            r_rx     <= '0;
            r_ry     <= '0;
            r_divq_x <= '0;
            r_divq_y <= '0;
        end else if (i_cmd.div_step) begin
            r_nx     <= {r_nx[CW-2:0], 1'b0};
            r_ny     <= {r_ny[CW-2:0], 1'b0};
            r_rx     <= ge_x ? SW'(trial_x - CW'(size_w)) : trial_x[SW-1:0];
            r_ry     <= ge_y ? SW'(trial_y - CW'(size_h)) : trial_y[SW-1:0];
            r_divq_x <= n_divq_x;
            r_divq_y <= n_divq_y;
            if (i_cmd.fin_s) begin
                r_cx     <= clamp_cell(n_divq_x, r_negx, xlim);
                r_cy     <= clamp_cell(n_divq_y, r_negy, ylim);
                r_nx     <= r_qx[CW-1:0];
                r_ny     <= r_qy[CW-1:0];
                r_negx   <= r_qx[CW];
                r_negy   <= r_qy[CW];
                r_rx     <= '0;
                r_ry     <= '0;
                r_divq_x <= '0;
                r_divq_y <= '0;
            end
            if (i_cmd.fin_e) begin
                r_ex <= clamp_cell(n_divq_x, r_negx, xlim);
                r_ey <= clamp_cell(n_divq_y, r_negy, ylim);
            end
        end else if (i_cmd.num) begin
            r_mx    <= PW'(numx);
            r_my    <= PW'(numy);
            r_wm    <= PW'(size_w);
            r_hm    <= PW'(size_h);
            r_tx    <= '0;
            r_ty    <= '0;
            r_wstep <= '0;
            r_hstep <= '0;
            r_bx    <= r_ady;
            r_by    <= r_adx;
        end else if (i_cmd.mul_step) begin
            if (r_bx[0]) begin
                r_tx    <= r_tx + r_mx;
                r_wstep <= r_wstep + r_wm;
            end
            if (r_by[0]) begin
                r_ty    <= r_ty + r_my;
                r_hstep <= r_hstep + r_hm;
            end
            r_mx <= r_mx <<< 1;
            r_my <= r_my <<< 1;
            r_wm <= r_wm << 1;
            r_hm <= r_hm << 1;
            r_bx <= r_bx >> 1;
            r_by <= r_by >> 1;
        end else if (i_cmd.walk && !last) begin
            if (step_x) begin
                r_cx <= (r_ex > r_cx) ? r_cx + 1'b1 : r_cx - 1'b1;
                r_tx <= r_tx + $signed(r_wstep);
            end else begin
                r_cy <= (r_ey > r_cy) ? r_cy + 1'b1 : r_cy - 1'b1;
                r_ty <= r_ty + $signed(r_hstep);
            end
        end
    end

    // output register
    logic                              r_m_valid;
    logic [lgct_pkg::IDX_OUT_W-1:0]    r_m_col, r_m_row;
    logic                              r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.walk) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_m_col  <= r_cx[lgct_pkg::IDX_OUT_W-1:0];
            r_m_row  <= r_cy[lgct_pkg::IDX_OUT_W-1:0];
            r_m_last <= last;
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = {6'b0, r_m_row, r_m_col};
    assign o_m_tlast    = r_m_last;
    assign o_sts.out_free = !r_m_valid || i_m_tready;
    assign o_sts.last     = last;

    ap_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && !last) |=> (r_cx != $past(r_cx)) || (r_cy != $past(r_cy)))
        else $error("walk step did not move");

    ap_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_cx <= xlim) && (r_cy <= ylim))
        else $error("walk left the grid");

    ap_step_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && !last && step_x) |-> need_x)
        else $error("x step with no x distance left");

endmodule

// ===== design/line_grid_cell_traversal_unit.sv =====
// ----------------------------------------------------------------------------
// line_grid_cell_traversal_unit
// Walks a line segment through a uniform 2D grid and emits each crossed cell.
// ----------------------------------------------------------------------------
// Sequence: restoring division of the start point, then of the end point,
//   one setup step, then shift-add for boundary times, before the first cell.
// Throughput: requests are taken only after the walk ends; one cell a cycle
//   during the walk when the sink is ready; at most columns + rows - 1 cells.
// Reset: synchronous active low; config returns to origin 0, cell 256 x 256,
//   one column and one row, and no cell is pending.
module line_grid_cell_traversal_unit #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lgct_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [lgct_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72]
    input  logic [4*lgct_pkg::COORD_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // cell_column[4:0], cell_row[9:5], zero fill[15:10]
    output logic [15:0]                       o_m_tdata,
    output logic                              o_m_tlast
);

    lgct_pkg::t_cmd cmd;
    lgct_pkg::t_sts sts;

    lgct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lgct_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule
